FILE: design/kll_pkg.sv
// ----------------------------------------------------------------------------
// kll_pkg: shared types and constants of the keyword lexer
// token kind codes, fixed field widths, character classes, keyword match
// ----------------------------------------------------------------------------
package kll_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 4;
  localparam int IDX_W  = 16;
  localparam int SPOS_W = 16;
  localparam int PFX_W  = 40;

  // kind + index + start + truncated + unknown byte; the length field comes on top
  localparam int FIXED_FIELD_W = KIND_W + IDX_W + SPOS_W + 1 + CHAR_W;

  localparam logic [IDX_W-1:0] MAX_TOKENS_RESET = 16'd1024;

  localparam logic [KIND_W-1:0] K_IDENT      = 4'd0;
  localparam logic [KIND_W-1:0] K_MATCH      = 4'd1;
  localparam logic [KIND_W-1:0] K_IF         = 4'd2;
  localparam logic [KIND_W-1:0] K_BOOL       = 4'd3;
  localparam logic [KIND_W-1:0] K_NUMBER     = 4'd4;
  localparam logic [KIND_W-1:0] K_STRING     = 4'd5;
  localparam logic [KIND_W-1:0] K_PIPE       = 4'd6;
  localparam logic [KIND_W-1:0] K_LBRACE     = 4'd7;
  localparam logic [KIND_W-1:0] K_RBRACE     = 4'd8;
  localparam logic [KIND_W-1:0] K_UNDERSCORE = 4'd9;
  localparam logic [KIND_W-1:0] K_ARROW      = 4'd10;
  localparam logic [KIND_W-1:0] K_UNKNOWN    = 4'd11;

  localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7c;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5f;
  localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  // keyword text packed first byte lowest
  localparam logic [PFX_W-1:0] PFX_MATCH = 40'h686374616d;
  localparam logic [PFX_W-1:0] PFX_IF    = 40'h0000006669;
  localparam logic [PFX_W-1:0] PFX_TRUE  = 40'h0065757274;
  localparam logic [PFX_W-1:0] PFX_FALSE = 40'h65736c6166;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } kll_q_stat_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic [KIND_W-1:0] word_kind(input logic [PFX_W-1:0] pfx,
                                                  input logic is2, input logic is4,
                                                  input logic is5, input logic trunc);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if (!trunc) begin
      if (is5 && (pfx == PFX_MATCH)) begin
        k = K_MATCH;
      end else if (is2 && (pfx == PFX_IF)) begin
        k = K_IF;
      end else if ((is4 && (pfx == PFX_TRUE)) || (is5 && (pfx == PFX_FALSE))) begin
        k = K_BOOL;
      end
    end
    return k;
  endfunction

endpackage

FILE: design/kll_scan.sv
// ----------------------------------------------------------------------------
// kll_scan: lexer front end
// takes one byte per cycle when in_accept, tracks the open token, builds up to two tokens
// ----------------------------------------------------------------------------
module kll_scan import kll_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 64,
  parameter int POSITION_BITS = 16,
  parameter int LEN_W         = 7,
  parameter int TOK_W         = 52
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [IDX_W-1:0]       cfg_wr_data,
  input  logic                   in_accept,
  input  logic [CHAR_W-1:0]      char_byte,
  input  logic                   end_of_input,
  output logic                   push,
  output logic [2*TOK_W:0]       push_data
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_EQUALS = 3'd4;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

  logic [2:0]               mode, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] tstart, tstart_next;
  logic [LEN_W-1:0]         tlen, tlen_next;
  logic                     ttrunc, ttrunc_next;
  logic [PFX_W-1:0]         prefix, prefix_next;
  logic [IDX_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         token_limit;

  logic [PFX_W-1:0]         ext_prefix;
  logic [LEN_W-1:0]         ext_len;
  logic                     ext_trunc;

  logic                     do_byte, do_flush, fall;
  logic                     a_vld, b_vld, a_ok, b_ok;
  logic [KIND_W-1:0]        a_kind, b_kind;
  logic [POSITION_BITS-1:0] a_start, b_start;
  logic [LEN_W-1:0]         a_len, b_len;
  logic                     a_trunc, b_trunc;
  logic [CHAR_W-1:0]        b_ubyte;
  logic [IDX_W-1:0]         cnt_a;
  logic [TOK_W-1:0]         a_data, b_data;

  assign do_byte  = (char_byte != CH_NUL);
  assign do_flush = end_of_input || !do_byte;

  // growing the open token by the current byte
  always_comb begin
    ext_prefix = prefix;
    if (tlen < LEN_W'(5)) begin
      ext_prefix = prefix | (PFX_W'(char_byte) << {tlen[2:0], 3'b000});
    end
    ext_len   = (tlen < LEN_MAX) ? LEN_W'(tlen + 1'b1) : tlen;
    ext_trunc = ttrunc || (tlen >= LEN_MAX);
  end

  always_comb begin
    mode_next   = mode;
    tstart_next = tstart;
    tlen_next   = tlen;
    ttrunc_next = ttrunc;
    prefix_next = prefix;
    fall        = 1'b0;
    a_vld       = 1'b0;
    a_kind      = K_IDENT;
    a_start     = tstart;
    a_len       = tlen;
    a_trunc     = ttrunc;
    b_vld       = 1'b0;
    b_kind      = K_IDENT;
    b_start     = pos;
    b_len       = LEN_W'(1);
    b_trunc     = 1'b0;
    b_ubyte     = CH_NUL;

    // byte against the open token
    if (do_byte) begin
      unique case (mode)
        MODE_IDENT: begin
          if (is_alpha(char_byte) || is_digit(char_byte) || (char_byte == CH_UNDER)) begin
            tlen_next   = ext_len;
            ttrunc_next = ext_trunc;
            prefix_next = ext_prefix;
          end else begin
            a_vld  = 1'b1;
            a_kind = word_kind(prefix, tlen == LEN_W'(2), tlen == LEN_W'(4),
                               tlen == LEN_W'(5), ttrunc);
            fall   = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(char_byte)) begin
            tlen_next   = ext_len;
            ttrunc_next = ext_trunc;
            prefix_next = ext_prefix;
          end else begin
            a_vld  = 1'b1;
            a_kind = K_NUMBER;
            fall   = 1'b1;
          end
        end
        MODE_STRING: begin
          if (char_byte == CH_QUOTE) begin
            a_vld     = 1'b1;
            a_kind    = K_STRING;
            mode_next = MODE_IDLE;
          end else begin
            tlen_next   = ext_len;
            ttrunc_next = ext_trunc;
            prefix_next = ext_prefix;
          end
        end
        MODE_EQUALS: begin
          if (char_byte == CH_GT) begin
            a_vld     = 1'b1;
            a_kind    = K_ARROW;
            a_len     = LEN_W'(2);
            a_trunc   = 1'b0;
            mode_next = MODE_IDLE;
          end else begin
            fall = 1'b1;
          end
        end
        default: begin
          fall = 1'b1;
        end
      endcase
    end

    // byte starts something new from idle
    if (fall) begin
      mode_next = MODE_IDLE;
      priority if (is_space(char_byte)) begin
        mode_next = MODE_IDLE;
      end else if (is_alpha(char_byte) || is_digit(char_byte)) begin
        mode_next   = is_alpha(char_byte) ? MODE_IDENT : MODE_NUMBER;
        tstart_next = pos;
        tlen_next   = LEN_W'(1);
        ttrunc_next = 1'b0;
        prefix_next = PFX_W'(char_byte);
      end else if (char_byte == CH_QUOTE) begin
        mode_next   = MODE_STRING;
        tstart_next = POSITION_BITS'(pos + 1'b1);
        tlen_next   = '0;
        ttrunc_next = 1'b0;
        prefix_next = '0;
      end else if (char_byte == CH_EQUALS) begin
        mode_next   = MODE_EQUALS;
        tstart_next = pos;
        tlen_next   = '0;
        ttrunc_next = 1'b0;
        prefix_next = '0;
      end else if (char_byte == CH_PIPE) begin
        b_vld  = 1'b1;
        b_kind = K_PIPE;
      end else if (char_byte == CH_LBRACE) begin
        b_vld  = 1'b1;
        b_kind = K_LBRACE;
      end else if (char_byte == CH_RBRACE) begin
        b_vld  = 1'b1;
        b_kind = K_RBRACE;
      end else if (char_byte == CH_UNDER) begin
        b_vld  = 1'b1;
        b_kind = K_UNDERSCORE;
      end else begin
        b_vld   = 1'b1;
        b_kind  = K_UNKNOWN;
        b_ubyte = char_byte;
      end
    end

    // end of input or a zero byte closes whatever is still open; a symbol above leaves it idle
    if (do_flush) begin
      if (mode_next == MODE_IDENT) begin
        b_vld   = 1'b1;
        b_kind  = word_kind(prefix_next, tlen_next == LEN_W'(2), tlen_next == LEN_W'(4),
                            tlen_next == LEN_W'(5), ttrunc_next);
        b_start = tstart_next;
        b_len   = tlen_next;
        b_trunc = ttrunc_next;
      end else if (mode_next == MODE_NUMBER) begin
        b_vld   = 1'b1;
        b_kind  = K_NUMBER;
        b_start = tstart_next;
        b_len   = tlen_next;
        b_trunc = ttrunc_next;
      end else if (mode_next == MODE_STRING) begin
        b_vld   = 1'b1;
        b_kind  = K_STRING;
        b_start = tstart_next;
        b_len   = tlen_next;
        b_trunc = ttrunc_next;
      end
      mode_next = MODE_IDLE;
    end
  end

  assign pos_next = do_flush ? '0 : POSITION_BITS'(pos + 1'b1);

  // token limit and sequence numbers
  assign a_ok       = a_vld && (count < token_limit);
  assign cnt_a      = IDX_W'(count + {{(IDX_W-1){1'b0}}, a_ok});
  assign b_ok       = b_vld && (cnt_a < token_limit);
  assign count_next = IDX_W'(cnt_a + {{(IDX_W-1){1'b0}}, b_ok});

  // fields from the lowest bit: kind, index, start, length, truncated, unknown byte
  assign a_data = {CH_NUL, a_trunc, a_len, SPOS_W'(a_start), count, a_kind};
  assign b_data = {b_ubyte, b_trunc, b_len, SPOS_W'(b_start), cnt_a, b_kind};

  assign push      = in_accept && (a_ok || b_ok);
  assign push_data = {a_ok && b_ok, b_data, a_ok ? a_data : b_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      pos         <= '0;
      tstart      <= '0;
      tlen        <= '0;
      ttrunc      <= 1'b0;
      prefix      <= '0;
      count       <= '0;
      token_limit <= MAX_TOKENS_RESET;
    end else begin
      if (cfg_wr_en) begin
        token_limit <= cfg_wr_data;
      end
      if (in_accept) begin
        mode   <= mode_next;
        pos    <= pos_next;
        tstart <= tstart_next;
        tlen   <= tlen_next;
        ttrunc <= ttrunc_next;
        prefix <= prefix_next;
        count  <= count_next;
      end
    end
  end

endmodule

FILE: design/kll_queue.sv
// ----------------------------------------------------------------------------
// kll_queue: short token queue
// decouples the scanner from the output side, power-of-two depth
// ----------------------------------------------------------------------------
module kll_queue import kll_pkg::*; #(
  parameter int WIDTH = 105,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output kll_q_stat_t      stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign stat.full  = (fill == CNT_W'(DEPTH));
  assign stat.empty = (fill == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= CNT_W'(fill + 1'b1);
        2'b01:   fill <= CNT_W'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/kll_emit.sv
// ----------------------------------------------------------------------------
// kll_emit: token output stage
// splits a queued token pair into single results and marks the last one
// ----------------------------------------------------------------------------
module kll_emit import kll_pkg::*; #(
  parameter int TOK_W  = 52,
  parameter int DATA_W = 56
) (
  input  logic              clk,
  input  logic              rst,
  input  kll_q_stat_t       q_stat,
  input  logic [2*TOK_W:0]  q_data,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,
  output logic              m_tlast
);

  logic             out_vld;
  logic [TOK_W-1:0] out_data;
  logic             out_last;
  logic             hold_vld;
  logic [TOK_W-1:0] hold_data;
  logic             load;
  logic             two;

  assign load  = !out_vld || m_tready;
  assign two   = q_data[2*TOK_W];
  assign q_pop = load && !hold_vld && !q_stat.empty;

  assign m_tvalid = out_vld;
  assign m_tdata  = DATA_W'(out_data);
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      hold_vld <= 1'b0;
      out_last <= 1'b0;
    end else if (load) begin
      if (hold_vld) begin
        out_vld  <= 1'b1;
        out_data <= hold_data;
        out_last <= 1'b1;
        hold_vld <= 1'b0;
      end else if (!q_stat.empty) begin
        out_vld   <= 1'b1;
        out_data  <= q_data[TOK_W-1:0];
        out_last  <= !two;
        hold_vld  <= two;
        hold_data <= q_data[2*TOK_W-1:TOK_W];
      end else begin
        out_vld <= 1'b0;
      end
    end
  end

endmodule

FILE: design/keyword_lexer_tokenizer.sv
// ----------------------------------------------------------------------------
// keyword_lexer_tokenizer: streaming keyword lexer
// one ASCII byte per request in, tokens with kind, index, position and length out
// ----------------------------------------------------------------------------
// The lexer takes one byte per clock cycle on the slave side while s_tready
// is high and gives back the tokens that each byte completes on the master
// side, zero, one or two per input request. A byte of zero, or a request with
// s_tlast set, closes the open token (an unterminated string is emitted as it
// stands) and sets the position back to zero. Whitespace is skipped and a
// lone '=' is dropped. Tokens past the token limit register are dropped and
// not counted; the register resets to 1024, and the user must write it
// through cfg_wr_en / cfg_wr_data only while the block is idle; the block
// does not enforce this. Text longer than MAX_TOKEN_LEN saturates the length
// and sets the truncated flag. Rate: the scanner takes a new byte every cycle
// while the queue is not full; its first token goes through the queue into
// the output register. The output stage sends one token per cycle while
// m_tready is high; a QUEUE_DEPTH-entry queue absorbs the bursts of bytes
// that make two tokens. s_tready drops only while that queue is full.
// ----------------------------------------------------------------------------
module keyword_lexer_tokenizer import kll_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 64,   // 8 .. 1024
  parameter int POSITION_BITS = 16,   // 8 .. 32
  parameter int QUEUE_DEPTH   = 4     // power of two, at least 2
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration: token limit
  input  logic                 cfg_wr_en,
  input  logic [IDX_W-1:0]     cfg_wr_data,
  // input bytes
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [CHAR_W-1:0]    s_tdata,   // char_byte
  input  logic                 s_tlast,   // end_of_input
  // tokens
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // token_kind, token_index, start_position, token_length, truncated,
  // unknown_byte, then zero fill
  output logic [((FIXED_FIELD_W + $clog2(MAX_TOKEN_LEN + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                 m_tlast    // last_of_run
);

  localparam int LEN_W   = $clog2(MAX_TOKEN_LEN + 1);
  localparam int TOK_W   = FIXED_FIELD_W + LEN_W;
  localparam int DATA_W  = ((TOK_W + 7) / 8) * 8;
  localparam int ENTRY_W = 2 * TOK_W + 1;

  logic               in_accept;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_data;
  kll_q_stat_t        q_stat;

  // a byte is taken whenever the queue has room for what it may produce
  assign s_tready  = !q_stat.full;
  assign in_accept = s_tvalid && s_tready;

  // front end: classification, open token tracking, token limit
  kll_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .POSITION_BITS (POSITION_BITS),
    .LEN_W         (LEN_W),
    .TOK_W         (TOK_W)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_accept    (in_accept),
    .char_byte    (s_tdata),
    .end_of_input (s_tlast),
    .push         (push),
    .push_data    (push_data)
  );

  // each entry holds the tokens of one byte: a pair flag and up to two tokens
  kll_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  // back end: one token per cycle while m_tready is high, registered
  kll_emit #(
    .TOK_W  (TOK_W),
    .DATA_W (DATA_W)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
